>>> rtl/core/rbs_pkg.sv
// rbs_pkg: shared constants and request/response types for the ray/box slab test
// no dependencies
package rbs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int NW        = W + 1;
    localparam int QW        = NW + FRAC_BITS;
    localparam int TW        = QW + 2;
    localparam int LANES     = 6;
    localparam int AXES      = 3;

    typedef struct packed {
        logic signed [W-1:0] origin_x;
        logic signed [W-1:0] origin_y;
        logic signed [W-1:0] origin_z;
        logic signed [W-1:0] direction_x;
        logic signed [W-1:0] direction_y;
        logic signed [W-1:0] direction_z;
        logic signed [W-1:0] box_min_x;
        logic signed [W-1:0] box_min_y;
        logic signed [W-1:0] box_min_z;
        logic signed [W-1:0] box_max_x;
        logic signed [W-1:0] box_max_y;
        logic signed [W-1:0] box_max_z;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic signed [W-1:0] hit_distance;
    } t_rsp;

endpackage

>>> rtl/core/ray_box_slab_intersect_top.sv
// ray_box_slab_intersect_top: pipelined fixed point ray / axis-aligned box slab test
// depends on rbs_pkg
//
// One request enters per cycle unless the output stalls; each request passes
// an operand setup register, then one restoring-division bit per stage across
// six parallel slab dividers (QW = 33 + fraction bits stages), then registers
// for per-axis entry/exit and the slab interval merge, and one output register.
// The whole pipeline holds while a response waits at the output.
module ray_box_slab_intersect_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rbs_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rbs_pkg::t_rsp o_out_rsp
);

    localparam int W  = rbs_pkg::W;
    localparam int NW = rbs_pkg::NW;
    localparam int QW = rbs_pkg::QW;
    localparam int TW = rbs_pkg::TW;
    localparam int F  = rbs_pkg::FRAC_BITS;
    localparam int L  = rbs_pkg::LANES;
    localparam int A  = rbs_pkg::AXES;
    localparam logic signed [TW-1:0] NEG_INF = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [TW-1:0] POS_INF = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_MAX = TW'({1'b0, {(W-1){1'b1}}});

    logic adv;

    logic signed [W-1:0] org [A];
    logic signed [W-1:0] dir [A];
    logic signed [W-1:0] bmn [A];
    logic signed [W-1:0] bmx [A];

    logic [QW-1:0] n_dvd [L];
    logic [W-1:0]  n_den [L];
    logic          n_neg [L];
    logic          n_dz  [A];
    logic          n_in  [A];

    // divider pipeline, index 0 is the setup stage
    logic [QW-1:0] r_dvd [QW+1][L];
    logic [W-1:0]  r_rem [QW+1][L];
    logic [W-1:0]  r_den [QW+1][L];
    logic          r_neg [QW+1][L];
    logic          r_dz  [QW+1][A];
    logic          r_in  [QW+1][A];
    logic          r_v   [QW+1];

    logic [QW-1:0] n_qd  [QW][L];
    logic [W-1:0]  n_qr  [QW][L];

    logic signed [TW-1:0] r_en [A];
    logic signed [TW-1:0] r_ex [A];
    logic                 r_ok1;
    logic                 r_v1;
    logic signed [TW-1:0] r_ten;
    logic signed [TW-1:0] r_tex;
    logic                 r_ok2;
    logic                 r_v2;
    logic                 r_ov;
    rbs_pkg::t_rsp        r_rsp;

    assign adv         = !r_ov || i_out_ready;
    assign o_in_ready  = adv;
    assign o_out_valid = r_ov;
    assign o_out_rsp   = r_rsp;

    assign org[0] = i_in_req.origin_x;
    assign org[1] = i_in_req.origin_y;
    assign org[2] = i_in_req.origin_z;
    assign dir[0] = i_in_req.direction_x;
    assign dir[1] = i_in_req.direction_y;
    assign dir[2] = i_in_req.direction_z;
    assign bmn[0] = i_in_req.box_min_x;
    assign bmn[1] = i_in_req.box_min_y;
    assign bmn[2] = i_in_req.box_min_z;
    assign bmx[0] = i_in_req.box_max_x;
    assign bmx[1] = i_in_req.box_max_y;
    assign bmx[2] = i_in_req.box_max_z;

    // operand setup
    always_comb begin
        logic signed [NW-1:0] diff;
        logic signed [NW-1:0] dext;
        logic [NW-1:0]        mag;
        logic [NW-1:0]        dmag;
        for (int ax = 0; ax < A; ax++) begin
            dext = NW'(dir[ax]);
            dmag = dext[NW-1] ? NW'(-dext) : NW'(dext);
            n_dz[ax] = (dir[ax] == '0);
            n_in[ax] = ((org[ax] >= bmn[ax]) && (org[ax] <= bmx[ax]))
                    || ((org[ax] >= bmx[ax]) && (org[ax] <= bmn[ax]));
            for (int k = 0; k < 2; k++) begin
                diff = (k == 0) ? (NW'(bmn[ax]) - NW'(org[ax]))
                                : (NW'(bmx[ax]) - NW'(org[ax]));
                mag  = diff[NW-1] ? NW'(-diff) : NW'(diff);
                n_dvd[2*ax+k] = {mag, {F{1'b0}}};
                n_den[2*ax+k] = dmag[W-1:0];
                n_neg[2*ax+k] = diff[NW-1] ^ dir[ax][W-1];
            end
        end
    end

    // one quotient bit per stage
    always_comb begin
        logic [W:0] rs;
        logic [W:0] sub;
        for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < L; l++) begin
                rs  = {r_rem[s][l], r_dvd[s][l][QW-1]};
                sub = rs - {1'b0, r_den[s][l]};
                if (!sub[W]) begin
                    n_qr[s][l] = sub[W-1:0];
                    n_qd[s][l] = {r_dvd[s][l][QW-2:0], 1'b1};
                end else begin
                    n_qr[s][l] = rs[W-1:0];
                    n_qd[s][l] = {r_dvd[s][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QW; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (adv) begin
            r_v[0] <= i_in_valid;
            for (int s = 0; s < QW; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < L; l++) begin
                r_dvd[0][l] <= n_dvd[l];
                r_rem[0][l] <= '0;
                r_den[0][l] <= n_den[l];
                r_neg[0][l] <= n_neg[l];
            end
            for (int ax = 0; ax < A; ax++) begin
                r_dz[0][ax] <= n_dz[ax];
                r_in[0][ax] <= n_in[ax];
            end
            for (int s = 0; s < QW; s++) begin
                for (int l = 0; l < L; l++) begin
                    r_dvd[s+1][l] <= n_qd[s][l];
                    r_rem[s+1][l] <= n_qr[s][l];
                    r_den[s+1][l] <= r_den[s][l];
                    r_neg[s+1][l] <= r_neg[s][l];
                end
                for (int ax = 0; ax < A; ax++) begin
                    r_dz[s+1][ax] <= r_dz[s][ax];
                    r_in[s+1][ax] <= r_in[s][ax];
                end
            end
        end
    end

    // per axis entry and exit
    always_ff @(posedge i_clk) begin
        logic signed [TW-1:0] t0;
        logic signed [TW-1:0] t1;
        logic                 ok;
        if (adv) begin
            ok = 1'b1;
            for (int ax = 0; ax < A; ax++) begin
                t0 = r_neg[QW][2*ax]   ? -TW'(r_dvd[QW][2*ax])   : TW'(r_dvd[QW][2*ax]);
                t1 = r_neg[QW][2*ax+1] ? -TW'(r_dvd[QW][2*ax+1]) : TW'(r_dvd[QW][2*ax+1]);
                if (r_dz[QW][ax]) begin
                    r_en[ax] <= NEG_INF;
                    r_ex[ax] <= POS_INF;
                    ok = ok && r_in[QW][ax];
                end else if (t0 < t1) begin
                    r_en[ax] <= t0;
                    r_ex[ax] <= t1;
                end else begin
                    r_en[ax] <= t1;
                    r_ex[ax] <= t0;
                end
            end
            r_ok1 <= ok;
        end
    end

    // interval merge
    always_ff @(posedge i_clk) begin
        logic signed [TW-1:0] en;
        logic signed [TW-1:0] ex;
        if (adv) begin
            en = (r_en[0] > r_en[1]) ? r_en[0] : r_en[1];
            ex = (r_ex[0] < r_ex[1]) ? r_ex[0] : r_ex[1];
            r_ten <= (r_en[2] > en) ? r_en[2] : en;
            r_tex <= (r_ex[2] < ex) ? r_ex[2] : ex;
            r_ok2 <= r_ok1;
        end
    end

    // hit decision and saturation
    always_ff @(posedge i_clk) begin
        logic signed [TW-1:0] d;
        if (adv) begin
            d = (r_ten >= 0) ? r_ten : r_tex;
            if (!r_ok2 || (r_ten > r_tex) || (r_tex < 0)) begin
                r_rsp.hit          <= 1'b0;
                r_rsp.hit_distance <= '0;
            end else begin
                r_rsp.hit          <= 1'b1;
                r_rsp.hit_distance <= (d > SAT_MAX) ? SAT_MAX[W-1:0] : d[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_v[QW];
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

endmodule
